// ----- design/bcme_pkg.sv -----
// Shared constants, command codes and state types of the bitmap cover mask engine.
package bcme_pkg;

  localparam int MASK_W           = 128;
  localparam int HALF_W           = 64;
  localparam int CNT_W            = 8;
  localparam int IDX_W            = 6;
  localparam int CMD_W            = 4;
  localparam int SLEN_W           = 8;
  localparam int IN_DATA_W        = 144;
  localparam int OUT_DATA_W       = 144;
  localparam int DEF_NUM_IP_MASKS = 64;

  localparam logic [CNT_W-1:0] FULL_COUNT = 8'd128;

  typedef enum logic [CMD_W-1:0] {
    CMD_INIT_ROW  = 4'd0,
    CMD_RESET     = 4'd1,
    CMD_BACKUP    = 4'd2,
    CMD_RESTORE   = 4'd3,
    CMD_LOAD      = 4'd4,
    CMD_STORE     = 4'd5,
    CMD_COVER     = 4'd6,
    CMD_UNCOVER   = 4'd7,
    CMD_CAN_COVER = 4'd8,
    CMD_OV_COVER  = 4'd9,
    CMD_CAN_OV    = 4'd10,
    CMD_OV_COUNT  = 4'd11,
    CMD_REFRESH   = 4'd12,
    CMD_HALF_OV   = 4'd13
  } cmd_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_FIN  = 2'd2
  } state_t;

endpackage

// ----- design/bcme_ckpt_mem.sv -----
// Checkpoint mask memory with one registered read port, one write port and per-entry valid bits.
module bcme_ckpt_mem
  import bcme_pkg::*;
#(
  parameter int DEPTH = DEF_NUM_IP_MASKS,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [MASK_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [MASK_W-1:0] wr_data
);

  logic [MASK_W-1:0] mem [DEPTH];
  logic [MASK_W-1:0] rd_raw_r;
  logic [DEPTH-1:0]  vld_r;
  logic              rd_vld_r;

  // Storage array: synchronous write, registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_raw_r <= mem[rd_addr];
    end
  end

  // Valid bits stand in for clearing the array; an unwritten entry reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_raw_r : '0;

endmodule

// ----- design/bitmap_cover_mask_engine.sv -----
// Top level of the bitmap cover mask engine: command sequencer, mask state and result register.
//
// The block keeps a 128-bit mask of uncovered items with its count, a backup
// copy of both, and a memory of checkpoint masks whose entry 0 holds the row.
// Requests enter on the in_ channel: in_tuser carries the command code and
// in_tdata the item set, its claimed length and a checkpoint index. Each
// request yields exactly one result on the out_ channel with the success
// flag, a count, the checkpoint index used by a load and the mask after
// the command.
// A request runs in order: the accept cycle issues the checkpoint
// memory read, the next cycle evaluates the command on the read data and
// performs any memory write, and the final state counts bits over 128-bit
// vectors and loads the output register once it is free. A new request is
// taken only in the idle state, after the previous one has left the final
// state, so requests do not overlap in the single read-modify-write pass
// through the checkpoint memory and the popcount stage.
// Reset (rst_n low, synchronous) clears the mask, counts and backup, marks
// every checkpoint entry as zero through valid bits, needs no clearing pass
// and leaves the block ready in the next cycle. While the receiver holds
// out_tready low the result stays in the output register; the next request
// may be accepted and evaluated, and it waits in its last stage until the
// output register frees.
module bitmap_cover_mask_engine
  import bcme_pkg::*;
#(
  parameter int NUM_IP_MASKS = DEF_NUM_IP_MASKS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // Fields from bit 0: item_mask_low[63:0], item_mask_high[127:64],
  // set_len[135:128], checkpoint_index[141:136], zero pad[143:142].
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // Fields from bit 0: cmd[3:0].
  input  logic [CMD_W-1:0]      in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // Fields from bit 0: ok[0], count_result[8:1], index_used[14:9],
  // mask_low[78:15], mask_high[142:79], zero pad[143].
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int AW = $clog2(NUM_IP_MASKS);
  localparam int CW = (AW > IDX_W) ? AW : IDX_W;

  // Popcount of a 128-bit vector as a tree of byte counts.
  function automatic logic [CNT_W-1:0] popcnt(input logic [MASK_W-1:0] v);
    logic [3:0] l0 [16];
    logic [4:0] l1 [8];
    logic [5:0] l2 [4];
    logic [6:0] l3 [2];
    for (int i = 0; i < 16; i++) begin
      l0[i] = '0;
      for (int b = 0; b < 8; b++) begin
        l0[i] = l0[i] + 4'(v[i*8+b]);
      end
    end
    for (int i = 0; i < 8; i++) begin
      l1[i] = 5'(l0[2*i]) + 5'(l0[2*i+1]);
    end
    for (int i = 0; i < 4; i++) begin
      l2[i] = 6'(l1[2*i]) + 6'(l1[2*i+1]);
    end
    for (int i = 0; i < 2; i++) begin
      l3[i] = 7'(l2[2*i]) + 7'(l2[2*i+1]);
    end
    return CNT_W'(l3[0]) + CNT_W'(l3[1]);
  endfunction

  // Request fields.
  logic [MASK_W-1:0] in_set;
  logic [SLEN_W-1:0] in_slen;
  logic [IDX_W-1:0]  in_idx;
  cmd_t              in_cmd;
  logic              in_fire;

  assign in_set  = in_tdata[MASK_W-1:0];
  assign in_slen = in_tdata[MASK_W+SLEN_W-1:MASK_W];
  assign in_idx  = in_tdata[MASK_W+SLEN_W+IDX_W-1:MASK_W+SLEN_W];
  assign in_cmd  = cmd_t'(in_tuser);
  assign in_fire = in_tvalid & in_tready;

  // Sequencer and architectural state.
  state_t            state_r, state_nxt;
  logic [CMD_W-1:0]  cmd_r;
  logic [MASK_W-1:0] set_r;
  logic [SLEN_W-1:0] slen_r;
  logic [AW-1:0]     idx_r;
  logic              idx_ok_r;
  logic [IDX_W-1:0]  used_r;
  logic [MASK_W-1:0] mask_r;
  logic [CNT_W-1:0]  count_r;
  logic [MASK_W-1:0] bk_mask_r;
  logic [CNT_W-1:0]  bk_count_r;
  logic [AW-1:0]     newest_r, newest_nxt;

  // Evaluation stage results.
  logic [MASK_W-1:0] pend_mask_r, pend_mask_nxt;
  logic [CNT_W-1:0]  pend_cnt_r, pend_cnt_nxt;
  logic [MASK_W-1:0] pop_vec_r, pop_vec_nxt;
  logic [MASK_W-1:0] out_vec_r, out_vec_nxt;
  logic              use_pop_r, use_pop_nxt;
  logic              commit_r, commit_nxt;
  logic              half_r, half_nxt;
  logic              ovc_r, ovc_nxt;
  logic              ok_r, ok_nxt;
  logic              bk_we;

  // Output register.
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  // Memory ports.
  logic [AW-1:0]     mem_raddr;
  logic [MASK_W-1:0] mem_rdata;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [MASK_W-1:0] mem_wdata;

  // Load index clamped to the newest valid checkpoint.
  logic [AW-1:0] in_idx_a;
  logic [AW-1:0] in_idx_clamp;
  logic          in_range;

  assign in_idx_a     = AW'(in_idx);
  assign in_idx_clamp = (CW'(in_idx) > CW'(newest_r)) ? newest_r : in_idx_a;
  assign in_range     = (32'(in_idx) < 32'(NUM_IP_MASKS));

  // Read address chosen at accept: the row entry, the clamped load entry or the refresh entry.
  always_comb begin
    unique case (in_cmd)
      CMD_LOAD:    mem_raddr = in_idx_clamp;
      CMD_REFRESH: mem_raddr = in_idx_a;
      default:     mem_raddr = '0;
    endcase
  end

  bcme_ckpt_mem #(
    .DEPTH (NUM_IP_MASKS),
    .AW    (AW)
  ) u_ckpt_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_fire),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata)
  );

  // Request capture.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r    <= in_tuser;
      set_r    <= in_set;
      slen_r   <= in_slen;
      idx_r    <= in_idx_a;
      idx_ok_r <= in_range;
      used_r   <= (in_cmd == CMD_LOAD) ? IDX_W'(in_idx_clamp) : '0;
    end
  end

  // Command evaluation against the mask, the count and the entry read from memory.
  logic          sub_mask;
  logic          sub_ent;
  logic          meets;
  logic [CNT_W:0] uncov_sum;

  assign sub_mask  = ((set_r & ~mask_r) == '0);
  assign sub_ent   = ((set_r & ~mem_rdata) == '0);
  assign meets     = |(mask_r & set_r);
  assign uncov_sum = {1'b0, count_r} + {1'b0, slen_r};

  always_comb begin
    pend_mask_nxt = mask_r;
    pend_cnt_nxt  = count_r;
    pop_vec_nxt   = '0;
    out_vec_nxt   = set_r & ~mask_r;
    use_pop_nxt   = 1'b0;
    commit_nxt    = 1'b0;
    half_nxt      = 1'b0;
    ovc_nxt       = 1'b0;
    ok_nxt        = 1'b0;
    bk_we         = 1'b0;
    newest_nxt    = newest_r;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = mask_r;
    if (state_r == S_EXEC) begin
      unique case (cmd_t'(cmd_r))
        CMD_INIT_ROW: begin
          pend_mask_nxt = set_r;
          pop_vec_nxt   = set_r;
          use_pop_nxt   = 1'b1;
          commit_nxt    = 1'b1;
          mem_we        = 1'b1;
          mem_wdata     = set_r;
          newest_nxt    = '0;
        end
        CMD_RESET, CMD_LOAD: begin
          pend_mask_nxt = mem_rdata;
          pop_vec_nxt   = mem_rdata;
          use_pop_nxt   = 1'b1;
          commit_nxt    = 1'b1;
        end
        CMD_BACKUP: begin
          bk_we = 1'b1;
        end
        CMD_RESTORE: begin
          pend_mask_nxt = bk_mask_r;
          pend_cnt_nxt  = bk_count_r;
          commit_nxt    = 1'b1;
        end
        CMD_STORE: begin
          if (idx_ok_r) begin
            mem_we     = 1'b1;
            mem_waddr  = idx_r;
            newest_nxt = idx_r;
          end
        end
        CMD_COVER, CMD_CAN_COVER: begin
          ok_nxt        = (slen_r <= count_r) && sub_mask;
          commit_nxt    = ok_nxt && (cmd_t'(cmd_r) == CMD_COVER);
          pend_mask_nxt = mask_r & ~set_r;
          pend_cnt_nxt  = count_r - slen_r;
        end
        CMD_UNCOVER: begin
          pend_mask_nxt = mask_r | set_r;
          pend_cnt_nxt  = (uncov_sum > {1'b0, FULL_COUNT}) ? FULL_COUNT
                                                           : uncov_sum[CNT_W-1:0];
          commit_nxt    = 1'b1;
        end
        CMD_OV_COVER, CMD_CAN_OV, CMD_HALF_OV: begin
          ok_nxt        = meets && sub_ent;
          commit_nxt    = ok_nxt && (cmd_t'(cmd_r) != CMD_CAN_OV);
          half_nxt      = (cmd_t'(cmd_r) == CMD_HALF_OV);
          pend_mask_nxt = mask_r & ~set_r;
          pop_vec_nxt   = mask_r & ~set_r;
          use_pop_nxt   = 1'b1;
        end
        CMD_OV_COUNT: begin
          pop_vec_nxt = mask_r & set_r;
          ovc_nxt     = 1'b1;
          ok_nxt      = 1'b1;
        end
        CMD_REFRESH: begin
          if (idx_ok_r) begin
            newest_nxt = idx_r;
            if (sub_ent) begin
              mem_we    = 1'b1;
              mem_waddr = idx_r;
              mem_wdata = mem_rdata & ~set_r;
              ok_nxt    = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_EXEC) begin
      pend_mask_r <= pend_mask_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
      pop_vec_r   <= pop_vec_nxt;
      out_vec_r   <= out_vec_nxt;
      use_pop_r   <= use_pop_nxt;
      commit_r    <= commit_nxt;
      half_r      <= half_nxt;
      ovc_r       <= ovc_nxt;
      ok_r        <= ok_nxt;
    end
  end

  // Final stage: bit counts, the half-overlap limit, commit and result.
  logic [CNT_W-1:0] pop_main;
  logic [CNT_W-1:0] pop_out;
  logic             gate;
  logic             commit_f;
  logic             ok_f;
  logic [CNT_W-1:0] new_cnt;
  logic [CNT_W-1:0] res_cnt;
  logic [MASK_W-1:0] res_mask;
  logic             fin_go;

  assign pop_main = popcnt(pop_vec_r);
  assign pop_out  = popcnt(out_vec_r);
  assign gate     = !half_r || (pop_out <= {1'b0, slen_r[SLEN_W-1:1]});
  assign commit_f = commit_r && gate;
  assign ok_f     = ok_r && gate;
  assign new_cnt  = use_pop_r ? pop_main : pend_cnt_r;
  assign res_cnt  = ovc_r ? pop_main : (commit_f ? new_cnt : count_r);
  assign res_mask = commit_f ? pend_mask_r : mask_r;
  assign fin_go   = (state_r == S_FIN) && (!out_valid_r || out_tready);

  // Architectural state updates.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r     <= '0;
      count_r    <= '0;
      bk_mask_r  <= '0;
      bk_count_r <= '0;
      newest_r   <= AW'(NUM_IP_MASKS - 1);
    end else begin
      newest_r <= newest_nxt;
      if (bk_we) begin
        bk_mask_r  <= mask_r;
        bk_count_r <= count_r;
      end
      if (fin_go && commit_f) begin
        mask_r  <= pend_mask_r;
        count_r <= new_cnt;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_data_r <= {1'b0, res_mask, used_r, res_cnt, ok_f};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and request ready.
  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Checks on the sequencer and the state.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_COUNT)
    else $error("uncovered count above full count");

  a_write_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_EXEC))
    else $error("checkpoint write outside evaluation");

  a_newest_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(newest_r) < 32'(NUM_IP_MASKS))
    else $error("newest checkpoint index out of range");

  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_EXEC))
    else $error("accepted request not evaluated next cycle");

  a_fin_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && out_valid_r && !out_tready) |=> (state_r == S_FIN))
    else $error("result stage left while output register is full");

endmodule

// ----- test/bitmap_cover_mask_engine_tb.sv -----
// Self-checking testbench for the bitmap cover mask engine: directed table, then random requests.
`timescale 1ns / 1ps

module bitmap_cover_mask_engine_tb;
  import bcme_pkg::*;

  localparam int NUM_MASKS     = DEF_NUM_IP_MASKS;
  localparam int DIR_ROWS      = 25;
  localparam int RANDOM_ITEMS  = 825;
  localparam int QUIET_FROM    = 745;
  localparam int HOLD_AT       = 300;
  localparam int DRAIN_AT      = 520;
  localparam int LONG_HOLD     = 60;
  localparam int SETTLE_CYCLES = 10;
  localparam int TIMEOUT_NS    = 3_000_000;

  // Command codes the block leaves unused.
  localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 4'd14;
  localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 4'd15;

  localparam logic [MASK_W-1:0] ALL_ONES  = {MASK_W{1'b1}};
  localparam logic [MASK_W-1:0] LOW_HALF  = {{HALF_W{1'b0}}, {HALF_W{1'b1}}};
  localparam logic [MASK_W-1:0] HIGH_HALF = {{HALF_W{1'b1}}, {HALF_W{1'b0}}};

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [MASK_W-1:0] item_set;
    logic [SLEN_W-1:0] set_len;
    logic [IDX_W-1:0]  ckpt_idx;
  } req_t;

  typedef struct packed {
    logic              ok;
    logic [CNT_W-1:0]  count;
    logic [IDX_W-1:0]  index_used;
    logic [MASK_W-1:0] mask;
  } res_t;

  typedef struct packed {
    req_t req;
    logic typed;
    res_t want;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [CMD_W-1:0]      in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  // Mirror of the engine state, advanced once per accepted request.
  logic [MASK_W-1:0] live_mask;
  logic [CNT_W-1:0]  live_count;
  logic [MASK_W-1:0] saved_mask;
  logic [CNT_W-1:0]  saved_count;
  logic [MASK_W-1:0] ckpt_tbl [NUM_MASKS];
  logic [IDX_W-1:0]  newest_idx;

  res_t due_results[$];
  int   fail_count = 0;
  bit   idle_on = 1'b1;
  bit   hold_off_req = 1'b0;

  // Directed requests; rows marked typed carry an expected result written out by hand.
  dir_row_t directed_rows [DIR_ROWS] = '{
    '{'{CMD_OV_COUNT,  ALL_ONES,       8'd128, 6'd0},  1'b1, '{1'b1, 8'd0,   6'd0,  128'd0}},
    '{'{CMD_LOAD,      128'd0,         8'd0,   6'd63}, 1'b1, '{1'b0, 8'd0,   6'd63, 128'd0}},
    '{'{CMD_INIT_ROW,  ALL_ONES,       8'd128, 6'd0},  1'b1, '{1'b0, 8'd128, 6'd0,  ALL_ONES}},
    '{'{CMD_COVER,     ALL_ONES,       8'd128, 6'd0},  1'b1, '{1'b1, 8'd0,   6'd0,  128'd0}},
    '{'{CMD_UNCOVER,   ALL_ONES,       8'd128, 6'd0},  1'b1, '{1'b0, 8'd128, 6'd0,  ALL_ONES}},
    '{'{CMD_UNCOVER,   128'd0,         8'd128, 6'd0},  1'b1, '{1'b0, 8'd128, 6'd0,  ALL_ONES}},
    '{'{CMD_BACKUP,    ALL_ONES,       8'd0,   6'd0},  1'b0, res_t'(0)},
    '{'{CMD_COVER,     LOW_HALF,       8'd64,  6'd0},  1'b1, '{1'b1, 8'd64,  6'd0,  HIGH_HALF}},
    '{'{CMD_CAN_COVER, 128'd1,         8'd1,   6'd0},  1'b0, res_t'(0)},
    '{'{CMD_COVER,     128'd1 << 64,   8'd65,  6'd0},  1'b0, res_t'(0)},
    '{'{CMD_STORE,     128'd0,         8'd0,   6'd5},  1'b0, res_t'(0)},
    '{'{CMD_RESTORE,   128'd0,         8'd0,   6'd0},  1'b0, res_t'(0)},
    '{'{CMD_LOAD,      128'd0,         8'd0,   6'd63}, 1'b0, res_t'(0)},
    '{'{CMD_LOAD,      128'd0,         8'd0,   6'd0},  1'b0, res_t'(0)},
    '{'{CMD_OV_COVER,  128'hF,         8'd4,   6'd0},  1'b0, res_t'(0)},
    '{'{CMD_CAN_OV,    128'hF,         8'd4,   6'd0},  1'b0, res_t'(0)},
    '{'{CMD_HALF_OV,   128'hFF,        8'd8,   6'd0},  1'b0, res_t'(0)},
    '{'{CMD_HALF_OV,   128'hFFFF,      8'd8,   6'd0},  1'b0, res_t'(0)},
    '{'{CMD_OV_COUNT,  ALL_ONES,       8'd0,   6'd0},  1'b0, res_t'(0)},
    '{'{CMD_REFRESH,   128'd1 << 127,  8'd1,   6'd0},  1'b0, res_t'(0)},
    '{'{CMD_REFRESH,   128'd1 << 127,  8'd1,   6'd0},  1'b0, res_t'(0)},
    '{'{CMD_STORE,     128'd0,         8'd0,   6'd0},  1'b0, res_t'(0)},
    '{'{CMD_UNUSED_LO, ALL_ONES,       8'd128, 6'd63}, 1'b0, res_t'(0)},
    '{'{CMD_UNUSED_HI, ALL_ONES,       8'd128, 6'd63}, 1'b0, res_t'(0)},
    '{'{CMD_RESET,     128'd0,         8'd0,   6'd0},  1'b0, res_t'(0)}
  };

  bitmap_cover_mask_engine dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  function automatic logic [CNT_W-1:0] count_ones(input logic [MASK_W-1:0] v);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < MASK_W; i++) n += v[i];
    return n;
  endfunction

  function automatic logic [MASK_W-1:0] rand_bits();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  task automatic clear_mirror();
    live_mask   = '0;
    live_count  = '0;
    saved_mask  = '0;
    saved_count = '0;
    for (int i = 0; i < NUM_MASKS; i++) ckpt_tbl[i] = '0;
    newest_idx = IDX_W'(NUM_MASKS - 1);
  endtask

  // Advance the mirror by one request and return the result it must produce.
  task automatic run_command(input req_t r, output res_t res);
    logic [MASK_W-1:0] row;
    logic [CNT_W:0]    sum;
    logic [CNT_W-1:0]  outside;
    logic              pass;
    row = ckpt_tbl[0];
    res = '0;
    case (r.cmd)
      CMD_INIT_ROW: begin
        live_mask   = r.item_set;
        live_count  = count_ones(r.item_set);
        ckpt_tbl[0] = r.item_set;
        newest_idx  = '0;
      end
      CMD_RESET: begin
        live_mask  = row;
        live_count = count_ones(row);
      end
      CMD_BACKUP: begin
        saved_mask  = live_mask;
        saved_count = live_count;
      end
      CMD_RESTORE: begin
        live_mask  = saved_mask;
        live_count = saved_count;
      end
      CMD_LOAD: begin
        res.index_used = (r.ckpt_idx > newest_idx) ? newest_idx : r.ckpt_idx;
        live_mask      = ckpt_tbl[res.index_used];
        live_count     = count_ones(live_mask);
      end
      CMD_STORE: begin
        ckpt_tbl[r.ckpt_idx] = live_mask;
        newest_idx           = r.ckpt_idx;
      end
      CMD_COVER, CMD_CAN_COVER: begin
        if (r.set_len <= live_count && (r.item_set & ~live_mask) == '0) begin
          res.ok = 1'b1;
          if (r.cmd == CMD_COVER) begin
            live_mask  = live_mask & ~r.item_set;
            live_count = live_count - r.set_len;
          end
        end
      end
      CMD_UNCOVER: begin
        live_mask  = live_mask | r.item_set;
        sum        = live_count + r.set_len;
        live_count = (sum > FULL_COUNT) ? FULL_COUNT : sum[CNT_W-1:0];
      end
      CMD_OV_COVER, CMD_CAN_OV, CMD_HALF_OV: begin
        pass = ((live_mask & r.item_set) != '0) && ((r.item_set & ~row) == '0);
        // Half overlap also refuses sets with too many items already covered.
        if (pass && r.cmd == CMD_HALF_OV) begin
          outside = count_ones(r.item_set & ~live_mask);
          if (outside > r.set_len / 2) pass = 1'b0;
        end
        if (pass) begin
          res.ok = 1'b1;
          if (r.cmd != CMD_CAN_OV) begin
            live_mask  = live_mask & ~r.item_set;
            live_count = count_ones(live_mask);
          end
        end
      end
      CMD_OV_COUNT: begin
        res.ok = 1'b1;
      end
      CMD_REFRESH: begin
        if ((r.item_set & ~ckpt_tbl[r.ckpt_idx]) == '0) begin
          ckpt_tbl[r.ckpt_idx] = ckpt_tbl[r.ckpt_idx] & ~r.item_set;
          res.ok               = 1'b1;
        end
        newest_idx = r.ckpt_idx;
      end
      default: begin
      end
    endcase
    res.count = (r.cmd == CMD_OV_COUNT) ? count_ones(live_mask & r.item_set) : live_count;
    res.mask  = live_mask;
  endtask

  // Offer one request, wait for it to be taken, then queue what it must return.
  task automatic send_request(input req_t r, input logic typed, input res_t typed_res);
    res_t predicted;
    in_tvalid <= 1'b1;
    in_tuser  <= r.cmd;
    in_tdata  <= {2'b00, r.ckpt_idx, r.set_len, r.item_set};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    run_command(r, predicted);
    due_results.push_back(typed ? typed_res : predicted);
  endtask

  task automatic maybe_pause_sender();
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 11);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
  endtask

  // Item sets drawn half the time from the live mask and the row, so covers can succeed.
  function automatic logic [MASK_W-1:0] pick_item_set();
    logic [MASK_W-1:0] a;
    logic [MASK_W-1:0] b;
    a = rand_bits();
    b = rand_bits();
    case ($urandom_range(0, 7))
      0:       return live_mask & a;
      1:       return live_mask & a & b;
      2:       return ckpt_tbl[0] & a & b;
      3:       return ckpt_tbl[0] & a;
      4:       return MASK_W'(1) << $urandom_range(0, MASK_W - 1);
      5:       return a;
      6:       return a & b & rand_bits();
      default: return $urandom_range(0, 1) ? ALL_ONES : '0;
    endcase
  endfunction

  function automatic logic [CMD_W-1:0] pick_command();
    int w;
    w = $urandom_range(0, 99);
    if (w < 4)  return CMD_INIT_ROW;
    if (w < 8)  return CMD_RESET;
    if (w < 12) return CMD_BACKUP;
    if (w < 16) return CMD_RESTORE;
    if (w < 21) return CMD_LOAD;
    if (w < 26) return CMD_STORE;
    if (w < 42) return CMD_COVER;
    if (w < 48) return CMD_UNCOVER;
    if (w < 56) return CMD_CAN_COVER;
    if (w < 66) return CMD_OV_COVER;
    if (w < 72) return CMD_CAN_OV;
    if (w < 78) return CMD_OV_COUNT;
    if (w < 84) return CMD_REFRESH;
    if (w < 96) return CMD_HALF_OV;
    if (w < 98) return CMD_UNUSED_LO;
    return CMD_UNUSED_HI;
  endfunction

  // Request source: reset, directed table, then random traffic.
  initial begin : request_source
    req_t r;
    clear_mirror();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
      maybe_pause_sender();
    end
    drain_results();

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      // A stretch without idling mid-run, and none at the end.
      idle_on = !((k >= 200 && k < 260) || k >= QUIET_FROM);
      if (k == HOLD_AT) hold_off_req = 1'b1;
      if (k == DRAIN_AT) drain_results();

      r.cmd = pick_command();
      if (r.cmd == CMD_INIT_ROW) begin
        case ($urandom_range(0, 3))
          0:       r.item_set = rand_bits();
          1:       r.item_set = rand_bits() | rand_bits();
          2:       r.item_set = rand_bits() | rand_bits() | rand_bits();
          default: r.item_set = ALL_ONES;
        endcase
      end else begin
        r.item_set = pick_item_set();
      end
      r.set_len  = ($urandom_range(0, 3) != 0) ? count_ones(r.item_set)
                                               : SLEN_W'($urandom_range(0, 128));
      r.ckpt_idx = $urandom_range(0, 1) ? IDX_W'($urandom_range(0, 7))
                                        : IDX_W'($urandom_range(0, NUM_MASKS - 1));
      send_request(r, 1'b0, res_t'(0));
      maybe_pause_sender();
    end
    in_tvalid <= 1'b0;

    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Result sink readiness: random stalls plus one long hold-off on request.
  initial begin : result_ready_gen
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = LONG_HOLD;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        if (idle_on && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 11);
      end
    end
  end

  // Compare every accepted result with the oldest outstanding expectation.
  always @(posedge clk) begin : result_check
    res_t got;
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[0], out_tdata[8:1], out_tdata[14:9], out_tdata[142:15]};
      if (due_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("result with no request outstanding: %h", got);
      end else begin
        want = due_results.pop_front();
        if (got.ok !== want.ok || got.count !== want.count ||
            got.index_used !== want.index_used || got.mask !== want.mask) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: ok %0b/%0b count %0d/%0d index %0d/%0d mask %h/%h",
                     want.ok, got.ok, want.count, got.count,
                     want.index_used, got.index_used, want.mask, got.mask);
        end
      end
    end
  end

  // Watchdog for a hung handshake.
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("FAIL");
    $finish;
  end

endmodule

// ----- sim.f -----
design/bcme_pkg.sv
design/bcme_ckpt_mem.sv
design/bitmap_cover_mask_engine.sv
test/bitmap_cover_mask_engine_tb.sv
